/* rtl/wols_pkg.sv */
package wols_pkg;

  localparam int unsigned MAX_WHEELS_DEF = 16;
  localparam int unsigned SUM_W          = 56;
  localparam int unsigned N_SUMS         = 9;
  localparam int unsigned WIDE_W         = 192;
  localparam int unsigned Q_BITS         = 32;
  localparam int unsigned FRAC_SH        = 16;
  localparam int unsigned CNT_W          = $clog2(SUM_W);
  localparam int unsigned IN_W           = 24;
  localparam int unsigned PROD_W         = 2 * IN_W;

  // ceil(2^64 / 1e6) and ceil(2^96 / 1e9)
  localparam logic [WIDE_W-1:0] THR_PLANAR = 192'd18446744073710;
  localparam logic [WIDE_W-1:0] THR_FULL   = 192'd79228162514264337594;

  localparam logic [3:0] PC_FULL   = 4'd0;
  localparam logic [3:0] PC_PLANAR = 4'd9;
  localparam logic [1:0] COL_DET   = 2'd3;

  localparam logic [3:0] IDX_XX = 4'd0;
  localparam logic [3:0] IDX_XY = 4'd1;
  localparam logic [3:0] IDX_XK = 4'd2;
  localparam logic [3:0] IDX_YY = 4'd3;
  localparam logic [3:0] IDX_YK = 4'd4;
  localparam logic [3:0] IDX_KK = 4'd5;
  localparam logic [3:0] IDX_RHS = 4'd6;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [N_SUMS-1:0] sums_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_ACC,
    T_START,
    T_SOLVE,
    T_FIN
  } top_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADA,
    S_LOADB,
    S_MUL,
    S_ABS,
    S_CHECK,
    S_DIV,
    S_DONE
  } solve_state_e;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic start;
    logic planar;
  } sol_ctrl_t;

  typedef struct packed {
    logic signed [Q_BITS-1:0] delta_x;
    logic signed [Q_BITS-1:0] delta_y;
    logic signed [Q_BITS-1:0] delta_heading;
    logic                     solved;
  } sol_res_t;

  typedef struct packed {
    logic       first;
    logic       neg;
    logic [1:0] ar;
    logic [1:0] ac;
    logic [1:0] br;
    logic [1:0] bc;
    logic       b_tmp;
    logic [1:0] b_t;
    logic       st;
    logic [1:0] st_t;
    logic       last;
  } prog_t;

  // cofactor expansion program, 3x3 then 2x2
  function automatic prog_t prog_entry(input logic [3:0] pc);
    prog_t e;
    case (pc)
      4'd0: e = '{1'b1, 1'b0, 2'd1, 2'd1, 2'd2, 2'd2, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0};
      4'd1: e = '{1'b0, 1'b1, 2'd1, 2'd2, 2'd2, 2'd1, 1'b0, 2'd0, 1'b1, 2'd0, 1'b0};
      4'd2: e = '{1'b1, 1'b0, 2'd1, 2'd0, 2'd2, 2'd2, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0};
      4'd3: e = '{1'b0, 1'b1, 2'd1, 2'd2, 2'd2, 2'd0, 1'b0, 2'd0, 1'b1, 2'd1, 1'b0};
      4'd4: e = '{1'b1, 1'b0, 2'd1, 2'd0, 2'd2, 2'd1, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0};
      4'd5: e = '{1'b0, 1'b1, 2'd1, 2'd1, 2'd2, 2'd0, 1'b0, 2'd0, 1'b1, 2'd2, 1'b0};
      4'd6: e = '{1'b1, 1'b0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b1, 2'd0, 1'b0, 2'd0, 1'b0};
      4'd7: e = '{1'b0, 1'b1, 2'd0, 2'd1, 2'd0, 2'd0, 1'b1, 2'd1, 1'b0, 2'd0, 1'b0};
      4'd8: e = '{1'b0, 1'b0, 2'd0, 2'd2, 2'd0, 2'd0, 1'b1, 2'd2, 1'b0, 2'd0, 1'b1};
      4'd9: e = '{1'b1, 1'b0, 2'd0, 2'd0, 2'd1, 2'd1, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0};
      4'd10: e = '{1'b0, 1'b1, 2'd0, 2'd1, 2'd1, 2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b1};
      default: e = '0;
    endcase
    return e;
  endfunction

  // symmetric normal matrix entry, or rhs when the column is replaced
  function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c,
                                         input logic [1:0] col);
    logic [3:0] idx;
    if (c == col) begin
      idx = IDX_RHS + {2'b00, r};
    end else begin
      case ({r, c})
        4'b0000: idx = IDX_XX;
        4'b0001, 4'b0100: idx = IDX_XY;
        4'b0010, 4'b1000: idx = IDX_XK;
        4'b0101: idx = IDX_YY;
        4'b0110, 4'b1001: idx = IDX_YK;
        default: idx = IDX_KK;
      endcase
    end
    return idx;
  endfunction

  function automatic logic [Q_BITS-1:0] sat_q(input logic [Q_BITS-1:0] q, input logic neg);
    logic [Q_BITS-1:0] r;
    if (q[Q_BITS-1]) begin
      r = neg ? {1'b1, {(Q_BITS-1){1'b0}}} : {1'b0, {(Q_BITS-1){1'b1}}};
    end else begin
      r = neg ? (~q + 1'b1) : q;
    end
    return r;
  endfunction

endpackage

/* rtl/wols_accum.sv */
module wols_accum #(
  parameter int unsigned MAX_WHEELS = wols_pkg::MAX_WHEELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wols_pkg::acc_ctrl_t ctrl_i,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  input  logic signed [23:0]  lever_arm_i,
  input  logic signed [23:0]  travel_i,
  output logic                busy_o,
  output wols_pkg::sums_t     sums_o
);
  import wols_pkg::*;

  localparam int unsigned ROWS_W = $clog2(MAX_WHEELS + 1);

  logic signed [17:0]       rx_q, ry_q;
  logic signed [IN_W-1:0]   rk_q, rm_q;
  logic signed [IN_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [3:0]               step_q;
  logic [3:0]               wr_idx;
  logic                     busy_q;
  logic [ROWS_W-1:0]        rows_q;
  sums_t                    sums_q;
  logic                     take;

  assign take   = ctrl_i.start && (rows_q < ROWS_W'(MAX_WHEELS));
  assign wr_idx = step_q - 4'd1;

  always_comb begin
    op_a = IN_W'(rx_q);
    op_b = IN_W'(rx_q);
    case (step_q)
      4'd0: begin op_a = IN_W'(rx_q); op_b = IN_W'(rx_q); end
      4'd1: begin op_a = IN_W'(rx_q); op_b = IN_W'(ry_q); end
      4'd2: begin op_a = IN_W'(rx_q); op_b = rk_q; end
      4'd3: begin op_a = IN_W'(ry_q); op_b = IN_W'(ry_q); end
      4'd4: begin op_a = IN_W'(ry_q); op_b = rk_q; end
      4'd5: begin op_a = rk_q; op_b = rk_q; end
      4'd6: begin op_a = IN_W'(rx_q); op_b = rm_q; end
      4'd7: begin op_a = IN_W'(ry_q); op_b = rm_q; end
      4'd8: begin op_a = rk_q; op_b = rm_q; end
      default: begin op_a = rk_q; op_b = rm_q; end
    endcase
  end

  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (take) begin
      rx_q <= {dir_x_i, 2'b00};
      ry_q <= {dir_y_i, 2'b00};
      rk_q <= lever_arm_i;
      rm_q <= travel_i;
    end
    if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      rows_q <= '0;
      sums_q <= '0;
    end else if (ctrl_i.clear) begin
      rows_q <= '0;
      sums_q <= '0;
    end else if (take) begin
      busy_q <= 1'b1;
      step_q <= '0;
      rows_q <= rows_q + 1'b1;
    end else if (busy_q) begin
      if (step_q != 4'd0) begin
        sums_q[wr_idx] <= sums_q[wr_idx] + SUM_W'(prod_q);
      end
      if (step_q == 4'd9) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + 4'd1;
    end
  end

  assign busy_o = busy_q;
  assign sums_o = sums_q;

endmodule

/* rtl/wols_solve.sv */
module wols_solve (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wols_pkg::sol_ctrl_t ctrl_i,
  input  wols_pkg::sums_t     sums_i,
  output logic                done_o,
  output wols_pkg::sol_res_t  res_o
);
  import wols_pkg::*;

  solve_state_e state_q, state_d;

  logic [3:0]        pc_q;
  logic [1:0]        col_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              planar_q;
  logic              ok_q;
  logic              neg_q;
  logic [WIDE_W-1:0] acc_q, mcand_q, det_mag_q, rem_q, dv_q;
  logic [WIDE_W-1:0] tmp_q [3];
  sum_t              mplier_q;
  logic              det_neg_q, qneg_q;
  logic [Q_BITS-1:0] quo_q, quo_d, quo_res;
  logic [Q_BITS-1:0] dx_q, dy_q, dh_q;

  prog_t             entry;
  logic [3:0]        rd_idx;
  sum_t              rd_val;
  logic [WIDE_W-1:0] alu_a, alu_b, alu_res, mag;
  logic              alu_sub, alu_geq;
  logic [WIDE_W:0]   alu_sum;
  logic              mul_last, div_last, last_col;
  logic [3:0]        start_pc;

  assign entry    = prog_entry(pc_q);
  assign rd_idx   = (state_q == S_LOADA) ? mat_idx(entry.ar, entry.ac, col_q)
                                         : mat_idx(entry.br, entry.bc, col_q);
  assign rd_val   = sums_i[rd_idx];
  assign mul_last = (cnt_q == CNT_W'(SUM_W - 1));
  assign div_last = (cnt_q == CNT_W'(Q_BITS - 1));
  assign last_col = planar_q ? (col_q == 2'd1) : (col_q == 2'd2);
  assign start_pc = planar_q ? PC_PLANAR : PC_FULL;

  // shared wide add / subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        alu_a   = acc_q;
        alu_b   = mcand_q;
        alu_sub = mul_last ^ neg_q;
      end
      S_ABS: begin
        alu_b   = acc_q;
        alu_sub = 1'b1;
      end
      S_CHECK: begin
        alu_a   = det_mag_q;
        alu_b   = planar_q ? THR_PLANAR : THR_FULL;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = rem_q;
        alu_b   = dv_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (WIDE_W + 1)'(alu_sub);
  assign alu_res = alu_sum[WIDE_W-1:0];
  assign alu_geq = alu_sum[WIDE_W];
  assign mag     = acc_q[WIDE_W-1] ? alu_res : acc_q;
  assign quo_d   = {quo_q[Q_BITS-2:0], alu_geq};
  assign quo_res = sat_q(quo_d, qneg_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (ctrl_i.start) state_d = S_LOADA;
      S_LOADA: state_d = S_LOADB;
      S_LOADB: state_d = S_MUL;
      S_MUL: begin
        if (mul_last) state_d = entry.last ? S_ABS : S_LOADA;
      end
      S_ABS:   state_d = (col_q == COL_DET) ? S_CHECK : S_DIV;
      S_CHECK: state_d = alu_geq ? S_LOADA : S_DONE;
      S_DIV: begin
        if (div_last) state_d = last_col ? S_DONE : S_LOADA;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      col_q    <= COL_DET;
      cnt_q    <= '0;
      planar_q <= 1'b0;
      ok_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (ctrl_i.start) begin
            planar_q <= ctrl_i.planar;
            pc_q     <= ctrl_i.planar ? PC_PLANAR : PC_FULL;
            col_q    <= COL_DET;
            ok_q     <= 1'b0;
          end
        end
        S_LOADB: cnt_q <= '0;
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (mul_last && !entry.last) pc_q <= pc_q + 4'd1;
        end
        S_ABS: cnt_q <= '0;
        S_CHECK: begin
          col_q <= 2'd0;
          pc_q  <= start_pc;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (div_last) begin
            if (last_col) begin
              ok_q <= 1'b1;
            end else begin
              col_q <= col_q + 2'd1;
              pc_q  <= start_pc;
            end
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (ctrl_i.start) begin
          dx_q <= '0;
          dy_q <= '0;
          dh_q <= '0;
        end
      end
      S_LOADA: begin
        if (entry.first) acc_q <= '0;
        mplier_q <= rd_val;
      end
      S_LOADB: begin
        mcand_q <= entry.b_tmp ? tmp_q[entry.b_t]
                               : {{(WIDE_W-SUM_W){rd_val[SUM_W-1]}}, rd_val};
        neg_q   <= entry.neg;
      end
      S_MUL: begin
        if (mplier_q[0]) acc_q <= alu_res;
        if (mul_last && entry.st) begin
          tmp_q[entry.st_t] <= mplier_q[0] ? alu_res : acc_q;
        end
        mcand_q  <= {mcand_q[WIDE_W-2:0], 1'b0};
        mplier_q <= mplier_q >>> 1;
      end
      S_ABS: begin
        if (col_q == COL_DET) begin
          det_mag_q <= mag;
          det_neg_q <= acc_q[WIDE_W-1];
        end else begin
          rem_q  <= mag << FRAC_SH;
          dv_q   <= det_mag_q << (Q_BITS - 1);
          qneg_q <= acc_q[WIDE_W-1] ^ det_neg_q;
          quo_q  <= '0;
        end
      end
      S_DIV: begin
        if (alu_geq) rem_q <= alu_res;
        dv_q  <= dv_q >> 1;
        quo_q <= quo_d;
        if (div_last) begin
          case (col_q)
            2'd0: dx_q <= quo_res;
            2'd1: dy_q <= quo_res;
            default: dh_q <= quo_res;
          endcase
        end
      end
      default: begin
        quo_q <= quo_q;
      end
    endcase
  end

  assign done_o              = (state_q == S_DONE);
  assign res_o.delta_x       = dx_q;
  assign res_o.delta_y       = dy_q;
  assign res_o.delta_heading = dh_q;
  assign res_o.solved        = ok_q;

endmodule

/* rtl/wheel_odometry_least_squares.sv */
// row without the last-row mark: 9 products on one 24x24 multiplier, each held in a product
//   register and then added into its sum; the next row is accepted only after the last add
// last row: adds the solve on one shared 192-bit add/subtract unit, which also does each
//   shift-add product; full 3x3 solve, or 2x2 when planar (heading_known set)
// result waits in an output register; the next row is taken while it waits
// reset clears the sums, the row count, heading_known and the output valid
module wheel_odometry_least_squares #(
  parameter int unsigned MAX_WHEELS = wols_pkg::MAX_WHEELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  input  logic signed [23:0]  lever_arm_i,
  input  logic signed [23:0]  travel_i,
  input  logic                last_row_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  delta_x_o,
  output logic signed [31:0]  delta_y_o,
  output logic signed [31:0]  delta_heading_o,
  output logic                solved_o
);
  import wols_pkg::*;

  top_state_e state_q, state_d;

  logic      heading_known_q;
  logic      last_q;
  logic      out_valid_q;
  logic      accept, out_free, acc_busy, sol_done;
  acc_ctrl_t acc_ctrl;
  sol_ctrl_t sol_ctrl;
  sums_t     sums;
  sol_res_t  sol_res, res_q;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  wols_accum #(
    .MAX_WHEELS(MAX_WHEELS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (acc_ctrl),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .lever_arm_i (lever_arm_i),
    .travel_i    (travel_i),
    .busy_o      (acc_busy),
    .sums_o      (sums)
  );

  wols_solve u_solve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sol_ctrl),
    .sums_i (sums),
    .done_o (sol_done),
    .res_o  (sol_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE:  if (accept) state_d = T_ACC;
      T_ACC: begin
        if (!acc_busy) state_d = last_q ? T_START : T_IDLE;
      end
      T_START: state_d = T_SOLVE;
      T_SOLVE: if (sol_done) state_d = T_FIN;
      T_FIN:   if (out_free) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == T_IDLE);
    acc_ctrl.start  = in_valid_i && (state_q == T_IDLE);
    acc_ctrl.clear  = (state_q == T_FIN) && out_free;
    sol_ctrl.start  = (state_q == T_START);
    sol_ctrl.planar = heading_known_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= T_IDLE;
      heading_known_q <= 1'b0;
      last_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) heading_known_q <= cfg_wdata_i;
      if (accept) last_q <= last_row_i;
      if ((state_q == T_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == T_FIN) && out_free) res_q <= sol_res;
  end

  assign out_valid_o     = out_valid_q;
  assign delta_x_o       = res_q.delta_x;
  assign delta_y_o       = res_q.delta_y;
  assign delta_heading_o = res_q.delta_heading;
  assign solved_o        = res_q.solved;

endmodule
